// ===== hw/rtl/cbsb_pkg.sv =====
// shared constants and types for the cardinal b-spline basis evaluator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cbsb_pkg;

  localparam int FRACTION_BITS_DEF = 16;

  localparam int POS_W   = 32;
  localparam int INV_W   = 32;
  localparam int ORDER_W = 3;
  localparam int OUT_W   = 17;
  localparam int CFG_IDX_W = 1;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd3;
  localparam logic [INV_W-1:0]   INV_RESET   = 32'd65536;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORDER     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE = 1'b1;

  // spline orders
  localparam logic [ORDER_W-1:0] ORD_BOX       = 3'd0;
  localparam logic [ORDER_W-1:0] ORD_HAT       = 3'd1;
  localparam logic [ORDER_W-1:0] ORD_QUADRATIC = 3'd2;
  localparam logic [ORDER_W-1:0] ORD_CUBIC     = 3'd3;
  localparam logic [ORDER_W-1:0] ORD_QUARTIC   = 3'd4;

  // polynomial piece selected for one word
  typedef enum logic [3:0] {
    PC_ZERO,
    PC_BOX,
    PC_HAT,
    PC_Q_IN,
    PC_Q_OUT,
    PC_C_IN,
    PC_C_OUT,
    PC_R_IN,
    PC_R_MID,
    PC_R_OUT
  } piece_e;

endpackage

`default_nettype wire

// ===== hw/rtl/cardinal_bspline_basis_eval.sv =====
// centred cardinal b-spline basis evaluator, orders 0 to 4, nine-stage pipeline
// depends on cbsb_pkg
//
// One position enters per clock: start_i is taken in every cycle and busy_o never rises.
// Each value leaves the pipeline registers with result_valid_o high for exactly
// one cycle; the receiver must take it then. The nine pipeline registers are:
// absolute value, the 32x32 scale multiply, interval selection, and one stage for each of
// the squaring, second and third products, the sum, the reciprocal multiply of the
// divide by three and its correction. spline_order and inverse_scale are written on the
// cfg channel, which is always ready, and must only change while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none

module cardinal_bspline_basis_eval #(
  parameter int FractionBits = cbsb_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic signed [cbsb_pkg::POS_W-1:0]   position_i,
  output logic                                     result_valid_o,
  output logic             [cbsb_pkg::OUT_W-1:0]   basis_value_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic        [cbsb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic        [cbsb_pkg::INV_W-1:0]   cfg_data_i
);

  localparam int Fb      = FractionBits;
  localparam int PosW    = cbsb_pkg::POS_W;
  localparam int OutW    = cbsb_pkg::OUT_W;
  localparam int OrdW    = cbsb_pkg::ORDER_W;
  localparam int PW      = 2 * PosW;
  localparam int TFW     = PW - Fb;
  localparam int TW      = Fb + 2;
  localparam int SqW     = 2 * TW;
  localparam int R1W     = Fb + 3;
  localparam int X2W     = Fb + 3;
  localparam int BW      = R1W + X2W;
  localparam int CW      = 2 * TW;
  localparam int EW      = Fb + 1;
  localparam int AW      = Fb + 3;
  localparam int NW      = Fb + 6;
  localparam int RW      = (EW > OutW) ? EW : OutW;
  localparam int Latency = 9;

  localparam longint Scale = longint'(1) << Fb;

  localparam logic [TFW-1:0] TSat    = TFW'(3 * Scale);
  localparam logic [TW-1:0]  TOne    = TW'(Scale);
  localparam logic [TW-1:0]  THalf   = TW'(Scale / 2);
  localparam logic [TW-1:0]  T3Half  = TW'(3 * Scale / 2);
  localparam logic [TW-1:0]  TTwo    = TW'(2 * Scale);
  localparam logic [TW-1:0]  T5Half  = TW'(5 * Scale / 2);
  localparam logic [TW-1:0]  TThree  = TW'(3 * Scale);
  localparam logic [EW-1:0]  EOne    = EW'(Scale);
  localparam logic [EW-1:0]  E3Quart = EW'(3 * Scale / 4);
  localparam logic [EW-1:0]  CubicC  = EW'((2 * Scale + 1) / 3);
  localparam logic [EW-1:0]  QuartC  = EW'((115 * Scale + 96) / 192);
  localparam logic [AW-1:0]  DivM    = AW'((longint'(1) << AW) / 3);
  localparam logic [OutW-1:0] ScaleOut = OutW'(Scale);

  // configuration
  logic [OrdW-1:0]            order_q;
  logic [cbsb_pkg::INV_W-1:0] inv_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= cbsb_pkg::ORDER_RESET;
      inv_q   <= cbsb_pkg::INV_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cbsb_pkg::REG_ORDER:     order_q <= cfg_data_i[OrdW-1:0];
        cbsb_pkg::REG_INV_SCALE: inv_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid bits
  logic [Latency-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[Latency-2:0], start_i && !busy_o};
    end
  end

  // stage 1: magnitude
  logic [PosW-1:0] mag1_d, mag1_q;
  logic [OrdW-1:0] ord1_q;

  assign mag1_d = position_i[PosW-1] ? (~position_i + PosW'(1)) : position_i;

  // stage 2: scale product
  logic [PW-1:0]   prod2_q;
  logic [OrdW-1:0] ord2_q;

  // stage 3: saturate and pick the piece
  logic [TFW-1:0]         tfull;
  logic [TW-1:0]          t3;
  cbsb_pkg::piece_e       piece3_d, piece3_q;
  logic [TW-1:0]          w3_d, w3_q, aux3_d, aux3_q;

  assign tfull = prod2_q[PW-1:Fb];
  assign t3    = (tfull > TSat) ? TThree : tfull[TW-1:0];

  always_comb begin
    piece3_d = cbsb_pkg::PC_ZERO;
    w3_d     = t3;
    aux3_d   = TTwo - t3;
    case (ord2_q)
      cbsb_pkg::ORD_BOX: begin
        if (t3 < THalf) piece3_d = cbsb_pkg::PC_BOX;
      end
      cbsb_pkg::ORD_HAT: begin
        if (t3 < TOne) begin
          piece3_d = cbsb_pkg::PC_HAT;
          w3_d     = TOne - t3;
        end
      end
      cbsb_pkg::ORD_QUADRATIC: begin
        if (t3 < THalf) begin
          piece3_d = cbsb_pkg::PC_Q_IN;
        end else if (t3 < T3Half) begin
          piece3_d = cbsb_pkg::PC_Q_OUT;
          w3_d     = T3Half - t3;
        end
      end
      cbsb_pkg::ORD_CUBIC: begin
        if (t3 < TOne) begin
          piece3_d = cbsb_pkg::PC_C_IN;
        end else if (t3 < TTwo) begin
          piece3_d = cbsb_pkg::PC_C_OUT;
          w3_d     = TTwo - t3;
        end
      end
      cbsb_pkg::ORD_QUARTIC: begin
        if (t3 < THalf) begin
          piece3_d = cbsb_pkg::PC_R_IN;
        end else if (t3 < T3Half) begin
          piece3_d = cbsb_pkg::PC_R_MID;
          w3_d     = T3Half - t3;
        end else if (t3 < T5Half) begin
          piece3_d = cbsb_pkg::PC_R_OUT;
          w3_d     = T5Half - t3;
        end
      end
      default: ;
    endcase
  end

  // stage 4: square
  logic [SqW-1:0]   sq4_q;
  cbsb_pkg::piece_e piece4_q;
  logic [TW-1:0]    w4_q, aux4_q;

  // stage 5: first rounding, second product, early pieces
  logic [SqW:0]     sq_rnd, sq_half;
  logic [R1W-1:0]   r1;
  logic [X2W-1:0]   x2;
  logic [EW-1:0]    early5_d;
  cbsb_pkg::piece_e piece5_q;
  logic [TW-1:0]    w5_q;
  logic [R1W-1:0]   r1_5_q;
  logic [BW-1:0]    b5_q;
  logic [EW-1:0]    early5_q;

  assign sq_rnd  = {1'b0, sq4_q} + (SqW+1)'(Scale / 2);
  assign sq_half = ({1'b0, sq4_q} + (SqW+1)'(Scale)) >> (Fb + 1);
  assign r1      = sq_rnd[Fb +: R1W];

  always_comb begin
    case (piece4_q)
      cbsb_pkg::PC_C_IN:  x2 = X2W'(aux4_q);
      cbsb_pkg::PC_R_IN:  x2 = X2W'(5 * Scale) - {r1[R1W-2:0], 1'b0};
      cbsb_pkg::PC_R_OUT: x2 = r1;
      default:            x2 = X2W'(w4_q);
    endcase
  end

  always_comb begin
    case (piece4_q)
      cbsb_pkg::PC_BOX:   early5_d = EOne;
      cbsb_pkg::PC_HAT:   early5_d = EW'(w4_q);
      cbsb_pkg::PC_Q_IN:  early5_d = E3Quart - EW'(r1);
      cbsb_pkg::PC_Q_OUT: early5_d = EW'(sq_half);
      default:            early5_d = '0;
    endcase
  end

  // stage 6: second rounding, third product
  logic [BW:0]      b_rnd, p_cubic, p_quart, a_cubic;
  logic [TW-1:0]    r2;
  logic [EW-1:0]    early6_d;
  logic [AW-1:0]    a6_d;
  cbsb_pkg::piece_e piece6_q;
  logic [TW-1:0]    w6_q, r2_6_q;
  logic [R1W-1:0]   r1_6_q;
  logic [CW-1:0]    c6_q;
  logic [EW-1:0]    early6_q;
  logic [AW-1:0]    a6_q;

  assign b_rnd   = {1'b0, b5_q} + (BW+1)'(Scale / 2);
  assign r2      = b_rnd[Fb +: TW];
  assign p_cubic = ({1'b0, b5_q} + (BW+1)'(Scale)) >> (Fb + 1);
  assign p_quart = ({1'b0, b5_q} + (BW+1)'(4 * Scale)) >> (Fb + 3);
  assign a_cubic = ({1'b0, b5_q} + (BW+1)'(3 * Scale)) >> (Fb + 1);

  always_comb begin
    early6_d = early5_q;
    a6_d     = '0;
    case (piece5_q)
      cbsb_pkg::PC_C_IN:  early6_d = CubicC - EW'(p_cubic);
      cbsb_pkg::PC_R_IN:  early6_d = QuartC - EW'(p_quart);
      cbsb_pkg::PC_C_OUT: a6_d     = AW'(a_cubic);
      cbsb_pkg::PC_R_OUT: a6_d     = (AW'(r2) + AW'(12)) >> 3;
      default: ;
    endcase
  end

  // stage 7: fourth power sum
  logic [CW:0]      c_rnd;
  logic [TW-1:0]    r3;
  logic [NW-1:0]    n7;
  logic [AW-1:0]    a7_d, a7_q;
  logic             div7_d, div7_q;
  logic [EW-1:0]    early7_q;

  assign c_rnd = {1'b0, c6_q} + (CW+1)'(Scale / 2);
  assign r3    = c_rnd[Fb +: TW];
  assign n7    = NW'(Scale) + (NW'(w6_q) << 2) + (NW'(r1_6_q) << 2) + (NW'(r1_6_q) << 1)
               + (NW'(r2_6_q) << 2) - (NW'(r3) << 2) + NW'(12);

  always_comb begin
    a7_d   = (piece6_q == cbsb_pkg::PC_R_MID) ? AW'(n7 >> 3) : a6_q;
    div7_d = piece6_q inside {cbsb_pkg::PC_C_OUT, cbsb_pkg::PC_R_MID, cbsb_pkg::PC_R_OUT};
  end

  // stage 8: reciprocal estimate of the divide by three
  logic [2*AW-1:0] qprod;
  logic [AW-1:0]   qe8_q, a8_q;
  logic            div8_q;
  logic [EW-1:0]   early8_q;

  assign qprod = (2*AW)'(a7_q) * (2*AW)'(DivM);

  // stage 9: correction and output
  logic [AW-1:0]   rem;
  logic [AW-1:0]   quot;
  logic [RW-1:0]   res_full;
  logic [OutW-1:0] basis_q;

  assign rem      = a8_q - ({qe8_q[AW-2:0], 1'b0} + qe8_q);
  assign quot     = (rem >= AW'(3)) ? qe8_q + AW'(1) : qe8_q;
  assign res_full = div8_q ? RW'(EW'(quot)) : RW'(early8_q);

  always_ff @(posedge clk_i) begin
    mag1_q   <= mag1_d;
    ord1_q   <= order_q;

    prod2_q  <= PW'(mag1_q) * PW'(inv_q);
    ord2_q   <= ord1_q;

    piece3_q <= piece3_d;
    w3_q     <= w3_d;
    aux3_q   <= aux3_d;

    sq4_q    <= SqW'(w3_q) * SqW'(w3_q);
    piece4_q <= piece3_q;
    w4_q     <= w3_q;
    aux4_q   <= aux3_q;

    piece5_q <= piece4_q;
    w5_q     <= w4_q;
    r1_5_q   <= r1;
    b5_q     <= BW'(r1) * BW'(x2);
    early5_q <= early5_d;

    piece6_q <= piece5_q;
    w6_q     <= w5_q;
    r1_6_q   <= r1_5_q;
    r2_6_q   <= r2;
    c6_q     <= CW'(r2) * CW'(w5_q);
    early6_q <= early6_d;
    a6_q     <= a6_d;

    a7_q     <= a7_d;
    div7_q   <= div7_d;
    early7_q <= early6_q;

    qe8_q    <= qprod[2*AW-1:AW];
    a8_q     <= a7_q;
    div8_q   <= div7_q;
    early8_q <= early7_q;

    basis_q  <= res_full[OutW-1:0];
  end

  assign result_valid_o = valid_q[Latency-1];
  assign basis_value_o  = basis_q;

  // checks
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##Latency result_valid_o)
    else $error("word did not leave after the pipeline latency");

  a_div_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[Latency-2] && div8_q |-> rem < AW'(6))
    else $error("divide by three estimate out of range");

  a_bad_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && (order_q > cbsb_pkg::ORD_QUARTIC) |-> ##Latency basis_value_o == '0)
    else $error("unsupported order gave a non-zero value");

  a_box : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && (order_q == cbsb_pkg::ORD_BOX)
      |-> ##Latency (basis_value_o == ScaleOut || basis_value_o == '0))
    else $error("box order gave a value other than one or zero");

endmodule

`default_nettype wire
